[rtl/american_put_grid_step_defines.svh]
// Assertion macros shared by the grid step block
`ifndef AMERICAN_PUT_GRID_STEP_DEFINES_SVH
`define AMERICAN_PUT_GRID_STEP_DEFINES_SVH
// Implication checked on every rising clock edge outside reset
`define APG_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Implication checked in the cycle after the antecedent
`define APG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

[rtl/apgs_pkg.sv]
// ----------------------------------------------------------------------------
// apgs_pkg
// Types and constants shared by the grid step controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none
package apgs_pkg;
   localparam int GRID_DEPTH_DEF = 16384;
   localparam int IDX_W = 14;
   localparam int VAL_W = 31;

   localparam logic [1:0] MODE_WRITE = 2'd0;
   localparam logic [1:0] MODE_READ  = 2'd1;
   localparam logic [1:0] MODE_STEP  = 2'd2;
   localparam logic [1:0] MODE_NOP   = 2'd3;

   localparam logic [2:0] REG_LEFT   = 3'd0;
   localparam logic [2:0] REG_CENTER = 3'd1;
   localparam logic [2:0] REG_RIGHT  = 3'd2;
   localparam logic [2:0] REG_LAST   = 3'd3;
   localparam logic [2:0] REG_START  = 3'd4;
   localparam logic [2:0] REG_SPACE  = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACCESS,
      ST_PRIME,
      ST_SWEEP,
      ST_DRAIN,
      ST_POS,
      ST_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       do_write;
      logic       do_read;
      logic       step_start;
      logic       sweep_run;
      logic       pos_start;
      logic       load_result;
      logic       refuse;
      logic       clear_result;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic       sweep_done;
      logic       pipe_empty;
      logic       pos_done;
      logic       coef_negative;
   } stat_type;
endpackage
`default_nettype wire

[rtl/apgs_ctrl.sv]
// ----------------------------------------------------------------------------
// apgs_ctrl
// Sequencer for write, read and time step transactions.
// ----------------------------------------------------------------------------
`default_nettype none
`include "american_put_grid_step_defines.svh"
module apgs_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_fire,
   input  wire logic [1:0]        req_mode,
   input  wire logic              rsp_fire,
   input  wire apgs_pkg::stat_type stat,
   output logic                   req_ready,
   output logic                   rsp_valid,
   output apgs_pkg::cmd_type      cmd
);
   apgs_pkg::state_type state_ff, state_in;
   logic [1:0] mode_ff, mode_in;

   // hold the mode of the transaction in flight
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= apgs_pkg::ST_IDLE;
         mode_ff  <= apgs_pkg::MODE_WRITE;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      case (state_ff)
         apgs_pkg::ST_IDLE: begin
            if (req_fire) begin
               mode_in = req_mode;
               if (req_mode == apgs_pkg::MODE_STEP && !stat.coef_negative)
                  state_in = apgs_pkg::ST_PRIME;
               else
                  state_in = apgs_pkg::ST_ACCESS;
            end
         end
         apgs_pkg::ST_ACCESS: state_in = apgs_pkg::ST_OUT;
         apgs_pkg::ST_PRIME:  state_in = apgs_pkg::ST_SWEEP;
         apgs_pkg::ST_SWEEP: begin
            if (stat.sweep_done) state_in = apgs_pkg::ST_DRAIN;
         end
         apgs_pkg::ST_DRAIN: begin
            if (stat.pipe_empty) state_in = apgs_pkg::ST_POS;
         end
         apgs_pkg::ST_POS: begin
            if (stat.pos_done) state_in = apgs_pkg::ST_OUT;
         end
         apgs_pkg::ST_OUT: begin
            if (rsp_fire) state_in = apgs_pkg::ST_IDLE;
         end
         default: state_in = apgs_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         apgs_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_fire) begin
               cmd.clear_result = 1'b1;
               cmd.do_write     = (req_mode == apgs_pkg::MODE_WRITE);
               cmd.do_read      = (req_mode == apgs_pkg::MODE_READ);
               cmd.refuse       = (req_mode == apgs_pkg::MODE_STEP) && stat.coef_negative;
               cmd.step_start   = (req_mode == apgs_pkg::MODE_STEP) && !stat.coef_negative;
            end
         end
         apgs_pkg::ST_ACCESS: cmd.load_result = (mode_ff == apgs_pkg::MODE_READ);
         apgs_pkg::ST_PRIME:  cmd.sweep_run = 1'b1;
         apgs_pkg::ST_SWEEP:  cmd.sweep_run = 1'b1;
         apgs_pkg::ST_DRAIN:  cmd.pos_start = stat.pipe_empty;
         apgs_pkg::ST_OUT:    rsp_valid = 1'b1;
         default: ;
      endcase
   end

   `APG_ASSERT_IMP(a_no_accept_busy, clock, reset, state_ff != apgs_pkg::ST_IDLE, !req_ready, "accept while busy")
   `APG_ASSERT_NEXT(a_out_holds, clock, reset, rsp_valid && !rsp_fire, rsp_valid, "result dropped")
   `APG_ASSERT_NEXT(a_done_leaves, clock, reset, state_ff == apgs_pkg::ST_SWEEP && stat.sweep_done, state_ff == apgs_pkg::ST_DRAIN, "sweep end missed")
endmodule
`default_nettype wire

[rtl/apgs_dp.sv]
// ----------------------------------------------------------------------------
// apgs_dp
// Grid stores, stencil pipeline, constraint sweep and position unit.
// ----------------------------------------------------------------------------
`default_nettype none
`include "american_put_grid_step_defines.svh"
module apgs_dp #(
   parameter int GRID_DEPTH = apgs_pkg::GRID_DEPTH_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire apgs_pkg::cmd_type         cmd,
   input  wire logic [apgs_pkg::IDX_W-1:0] req_index,
   input  wire logic [apgs_pkg::VAL_W-1:0] req_value,
   input  wire logic [apgs_pkg::VAL_W-1:0] req_intrinsic,
   input  wire logic [31:0]               coef_left,
   input  wire logic [31:0]               coef_center,
   input  wire logic [31:0]               coef_right,
   input  wire logic [13:0]               grid_last,
   input  wire logic [31:0]               start_position,
   input  wire logic [30:0]               spacing,
   output apgs_pkg::stat_type             stat,
   output logic                           status_ff,
   output logic [apgs_pkg::VAL_W-1:0]      read_value_ff,
   output logic [apgs_pkg::VAL_W-1:0]      read_intrinsic_ff,
   output logic [apgs_pkg::IDX_W-1:0]      crit_index_ff,
   output logic [31:0]                    crit_position_ff
);
   localparam int AW = $clog2(GRID_DEPTH);
   localparam int LW = AW + 1;
   localparam int VW = apgs_pkg::VAL_W;
   localparam logic [LW-1:0] LAST_MAX = LW'(GRID_DEPTH - 1);

   logic [VW-1:0] sol_mem [GRID_DEPTH];
   logic [VW-1:0] itr_mem [GRID_DEPTH];

   // effective last index, clamped
   logic [LW-1:0] last_ff, last_in;
   always_comb begin
      last_in = LW'(grid_last);
      if (last_in < LW'(2)) last_in = LW'(2);
      if (last_in > LAST_MAX) last_in = LAST_MAX;
   end

   // sweep read address and pipeline
   logic [LW-1:0] rd_ptr_ff;
   logic          rd_en;
   logic          in_range;
   logic          rd_ok_ff;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] acc_addr;
   logic [VW-1:0] sol_q_ff, itr_q_ff;

   assign in_range = (LW'(req_index) < LW'(GRID_DEPTH));
   assign acc_addr = AW'(req_index);
   assign rd_en    = cmd.sweep_run;
   assign rd_addr  = cmd.sweep_run ? rd_ptr_ff[AW-1:0] : acc_addr;

   always_ff @(posedge clock) begin
      if (reset) rd_ptr_ff <= '0;
      else if (cmd.step_start) rd_ptr_ff <= '0;
      else if (rd_en && rd_ptr_ff <= last_ff) rd_ptr_ff <= rd_ptr_ff + LW'(1);
   end

   assign stat.sweep_done = cmd.sweep_run && (rd_ptr_ff == last_ff);

   // stage valid bits: s1 data out of memory, s2 window ready, s3 products, s4 sum
   logic          v1_ff, v2_ff, v3_ff, v4_ff;
   logic [LW-1:0] i1_ff, i2_ff, i3_ff, i4_ff;
   logic [VW-1:0] wl_ff, wm_ff, wr_ff;
   logic [VW-1:0] t2_ff, t3_ff, tq_ff, t4_ff;
   logic [62:0]   pl_ff, pm_ff, pr_ff;
   logic [VW-1:0] nv4_ff;
   logic          bind_ff;
   logic [LW-1:0] crit_ff;
   logic          fill_ff;

   // write port: host write or sweep writeback
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [VW-1:0] wr_data;
   logic          keep;
   logic [64:0]   sum;
   logic [34:0]   rnd;
   always_comb begin
      sum = 65'(pl_ff) + 65'(pm_ff) + 65'(pr_ff) + 65'(64'd1 << 29);
      rnd = sum[64:30];
      keep = bind_ff && !(nv4_ff > t4_ff);
      wr_en   = cmd.do_write && in_range;
      wr_addr = acc_addr;
      wr_data = req_value;
      if (v4_ff) begin
         wr_en   = 1'b1;
         wr_addr = i4_ff[AW-1:0];
         wr_data = keep ? t4_ff : nv4_ff;
      end
   end

   // memories, registered reads
   always_ff @(posedge clock) begin
      if (wr_en) sol_mem[wr_addr] <= wr_data;
      if (cmd.do_write && in_range && !v4_ff) itr_mem[acc_addr] <= req_intrinsic;
      sol_q_ff <= sol_mem[rd_addr];
      itr_q_ff <= itr_mem[rd_addr];
      if (cmd.do_read) rd_ok_ff <= in_range;
   end

   // advance the stencil pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0;
         bind_ff <= 1'b1; fill_ff <= 1'b0;
      end else begin
         v1_ff <= rd_en && rd_ptr_ff <= last_ff;
         if (cmd.step_start) begin
            bind_ff <= 1'b1; fill_ff <= 1'b0;
         end
         // window shift; valid once index i+1 has arrived
         if (v1_ff) fill_ff <= 1'b1;
         v2_ff <= v1_ff && fill_ff && i1_ff >= LW'(2);
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         if (v4_ff && bind_ff && nv4_ff > t4_ff) bind_ff <= 1'b0;
      end
      if (cmd.step_start) last_ff <= last_in;
      if (cmd.step_start) crit_ff <= last_in;
      else if (v4_ff && bind_ff && nv4_ff > t4_ff) crit_ff <= i4_ff;
      i1_ff <= rd_ptr_ff;
      if (v1_ff) begin
         wl_ff <= wm_ff; wm_ff <= wr_ff; wr_ff <= sol_q_ff;
         t2_ff <= t3_ff; t3_ff <= itr_q_ff;
      end
      i2_ff <= i1_ff - LW'(1);
      pl_ff <= 63'(coef_left[30:0]) * 63'(wl_ff);
      pm_ff <= 63'(coef_center[30:0]) * 63'(wm_ff);
      pr_ff <= 63'(coef_right[30:0]) * 63'(wr_ff);
      // delay the intrinsic value two stages to meet the rounded sum
      tq_ff <= t2_ff;
      t4_ff <= tq_ff;
      i3_ff <= i2_ff;
      i4_ff <= i3_ff;
      nv4_ff <= (rnd > 35'(32'h7FFFFFFF)) ? {VW{1'b1}} : rnd[VW-1:0];
   end

   assign stat.pipe_empty    = !v1_ff && !v2_ff && !v3_ff && !v4_ff;
   assign stat.coef_negative = coef_left[31] | coef_center[31] | coef_right[31];

   // position: start + crit*spacing, registered multiply then combinational add
   logic [1:0]  pos_cnt_ff;
   logic [44:0] prod_ff;
   logic signed [46:0] psum;
   always_ff @(posedge clock) begin
      if (reset) pos_cnt_ff <= '0;
      else if (cmd.pos_start) pos_cnt_ff <= 2'd1;
      else if (pos_cnt_ff != 2'd0) pos_cnt_ff <= pos_cnt_ff + 2'd1;
      prod_ff <= 45'(crit_ff[13:0]) * 45'(spacing);
   end
   assign stat.pos_done = (pos_cnt_ff == 2'd2);
   assign psum = 47'(signed'(start_position)) + signed'({2'b00, prod_ff});

   // result register
   always_ff @(posedge clock) begin
      if (cmd.clear_result) begin
         status_ff <= cmd.refuse;
         read_value_ff <= '0; read_intrinsic_ff <= '0;
         crit_index_ff <= '0; crit_position_ff <= '0;
      end
      if (cmd.load_result && rd_ok_ff) begin
         read_value_ff <= sol_q_ff; read_intrinsic_ff <= itr_q_ff;
      end
      if (stat.pos_done) begin
         crit_index_ff <= crit_ff[13:0];
         if (psum > 47'sd2147483647) crit_position_ff <= 32'h7FFFFFFF;
         else crit_position_ff <= psum[31:0];
      end
   end

   `APG_ASSERT_IMP(a_wb_range, clock, reset, v4_ff, i4_ff < last_ff && i4_ff != '0, "writeback outside interior")
   `APG_ASSERT_IMP(a_no_host_in_sweep, clock, reset, cmd.sweep_run, !cmd.do_write, "host write during sweep")
   `APG_ASSERT_IMP(a_crit_range, clock, reset, stat.pos_done, crit_ff != '0 && crit_ff <= last_ff, "bad critical index")
endmodule
`default_nettype wire

[rtl/american_put_grid_step.sv]
// ----------------------------------------------------------------------------
// american_put_grid_step
// Explicit finite-difference step of an American put with exercise check.
// ----------------------------------------------------------------------------
// channel   dir  signals
// req       in   req_tvalid/tready, tdata = mode, index, value, intrinsic
// rsp       out  rsp_tvalid/tready, tdata = status, read_value, read_intrinsic,
//                crit_index, crit_position
// csr       in   APB write/read, six registers at 4*i
// Writes and reads pass through the access state to the response handshake.
// A step reads one grid point per cycle from the single read port of the
// solution store, then drains the pipeline and adds the position.
// Reset is synchronous; stores are not cleared. One transaction at a time;
// the response waits in its register while rsp_tready is low.
// ----------------------------------------------------------------------------
`default_nettype none
module american_put_grid_step #(
   parameter int GRID_DEPTH = apgs_pkg::GRID_DEPTH_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // mode[1:0], index[15:2], value[46:16], intrinsic[77:47]
   input  wire logic [79:0]  req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // status[0], read_value[31:1], read_intrinsic[62:32], crit_index[76:63],
   // crit_position[108:77]
   output logic [111:0]      rsp_tdata,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [4:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   logic [31:0] left_ff, center_ff, right_ff, start_ff;
   logic [13:0] last_ff;
   logic [30:0] space_ff;
   logic [2:0]  reg_sel;
   apgs_pkg::cmd_type  cmd;
   apgs_pkg::stat_type stat;
   logic st_ff;
   logic [30:0] rv_ff, ri_ff;
   logic [13:0] ci_ff;
   logic [31:0] cp_ff;

   assign csr_pready = 1'b1;
   assign reg_sel = csr_paddr[4:2];

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0; center_ff <= 32'h40000000; right_ff <= '0;
         last_ff <= 14'h3FFF; start_ff <= '0; space_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (reg_sel)
            apgs_pkg::REG_LEFT:   left_ff   <= csr_pwdata;
            apgs_pkg::REG_CENTER: center_ff <= csr_pwdata;
            apgs_pkg::REG_RIGHT:  right_ff  <= csr_pwdata;
            apgs_pkg::REG_LAST:   last_ff   <= csr_pwdata[13:0];
            apgs_pkg::REG_START:  start_ff  <= csr_pwdata;
            apgs_pkg::REG_SPACE:  space_ff  <= csr_pwdata[30:0];
            default: ;
         endcase
      end
   end

   // register reads
   always_comb begin
      case (reg_sel)
         apgs_pkg::REG_LEFT:   csr_prdata = left_ff;
         apgs_pkg::REG_CENTER: csr_prdata = center_ff;
         apgs_pkg::REG_RIGHT:  csr_prdata = right_ff;
         apgs_pkg::REG_LAST:   csr_prdata = {18'd0, last_ff};
         apgs_pkg::REG_START:  csr_prdata = start_ff;
         apgs_pkg::REG_SPACE:  csr_prdata = {1'b0, space_ff};
         default:              csr_prdata = '0;
      endcase
   end

   apgs_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_fire(req_tvalid && req_tready), .req_mode(req_tdata[1:0]),
      .rsp_fire(rsp_tvalid && rsp_tready), .stat(stat),
      .req_ready(req_tready), .rsp_valid(rsp_tvalid), .cmd(cmd)
   );

   apgs_dp #(.GRID_DEPTH(GRID_DEPTH)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd),
      .req_index(req_tdata[15:2]), .req_value(req_tdata[46:16]),
      .req_intrinsic(req_tdata[77:47]),
      .coef_left(left_ff), .coef_center(center_ff), .coef_right(right_ff),
      .grid_last(last_ff), .start_position(start_ff), .spacing(space_ff),
      .stat(stat), .status_ff(st_ff), .read_value_ff(rv_ff),
      .read_intrinsic_ff(ri_ff), .crit_index_ff(ci_ff), .crit_position_ff(cp_ff)
   );

   assign rsp_tdata = {3'd0, cp_ff, ci_ff, ri_ff, rv_ff, st_ff};
endmodule
`default_nettype wire
